@@ rtl/fdi_pkg.sv @@
package fdi_pkg;

  // Store and number formats
  localparam int STORE_DEPTH   = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD_BITS    = 3;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LEN_W  = ADDR_W + 1;
  localparam int POS_W  = ADDR_W + FRACTION_BITS;
  localparam int MODE_W = 2;

  // Cubic coefficients need four bits of headroom over a sample; the Horner
  // accumulator needs fourteen. The product adds the unsigned fraction.
  localparam int COEF_W = SAMPLE_BITS + 4;
  localparam int ACC_W  = SAMPLE_BITS + 14;
  localparam int PROD_W = ACC_W + FRACTION_BITS + 1;

  // Stream packing
  localparam int IN_DATA_BITS  = ADDR_W + SAMPLE_BITS + POS_W;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IDX_LSB       = 0;
  localparam int VAL_LSB       = ADDR_W;
  localparam int POS_LSB       = ADDR_W + SAMPLE_BITS;
  localparam int OUT_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RESET   = MODE_LINEAR;
  localparam logic [LEN_W-1:0]  LEN_RESET    = LEN_W'(STORE_DEPTH);
  localparam logic [LEN_W-1:0]  LEN_MIN      = LEN_W'(4);
  localparam logic [LEN_W-1:0]  LEN_MAX      = LEN_W'(STORE_DEPTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_INTERP_MODE   = 1'b0;
  localparam logic REG_BUFFER_LENGTH = 1'b1;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COEF,
    S_MAC,
    S_MWAIT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    KIND_NEAREST,
    KIND_LINEAR,
    KIND_CUBIC
  } kind_e;

  // One request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                    start;
    logic                    guard_shift;
    logic                    round;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
  } mac_req_t;

endpackage

@@ rtl/fdi_store.sv @@
module fdi_store (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [fdi_pkg::ADDR_W-1:0]            wr_addr_i,
  input  logic signed [fdi_pkg::SAMPLE_BITS-1:0] wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [fdi_pkg::ADDR_W-1:0]            rd_addr_i,
  output logic signed [fdi_pkg::SAMPLE_BITS-1:0] rd_data_o
);

  logic signed [fdi_pkg::SAMPLE_BITS-1:0] mem_q [fdi_pkg::STORE_DEPTH];
  logic signed [fdi_pkg::SAMPLE_BITS-1:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/fdi_mac.sv @@
module fdi_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fdi_pkg::mac_req_t                      req_i,
  input  logic [fdi_pkg::FRACTION_BITS-1:0]      frac_i,
  output logic signed [fdi_pkg::ACC_W-1:0]       res_o,
  output logic                                   res_valid_o
);

  logic signed [fdi_pkg::FRACTION_BITS:0]  frac_s;
  logic signed [fdi_pkg::PROD_W-1:0]       prod_d;
  logic signed [fdi_pkg::PROD_W-1:0]       prod_q;
  logic signed [fdi_pkg::ACC_W-1:0]        b_q;
  logic                                    guard_q;
  logic                                    round_q;
  logic                                    v1_q;
  logic                                    v2_q;
  logic signed [fdi_pkg::PROD_W-1:0]       rounded;
  logic signed [fdi_pkg::PROD_W-1:0]       shifted;
  logic signed [fdi_pkg::ACC_W-1:0]        res_d;
  logic signed [fdi_pkg::ACC_W-1:0]        res_q;

  // First stage: the single multiplier, accumulator times the fraction.
  assign frac_s = $signed({1'b0, frac_i});
  assign prod_d = req_i.a * frac_s;

  // Second stage: optional half-unit rounding, floor shift, then add.
  always_comb begin
    rounded = prod_q;
    if (round_q) begin
      rounded = prod_q + fdi_pkg::PROD_W'(2 ** (fdi_pkg::FRACTION_BITS - 1));
    end
    if (guard_q) begin
      shifted = rounded >>> (fdi_pkg::FRACTION_BITS - fdi_pkg::GUARD_BITS);
    end else begin
      shifted = rounded >>> fdi_pkg::FRACTION_BITS;
    end
    res_d = shifted[fdi_pkg::ACC_W-1:0] + b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.start;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q  <= prod_d;
      b_q     <= req_i.b;
      guard_q <= req_i.guard_shift;
      round_q <= req_i.round;
    end
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = v2_q;

endmodule

@@ rtl/fractional_delay_interpolator.sv @@
// Fractional delay interpolator.
// Input stream: tuser is the operation (0 write, 1 read). A write item loads
// one entry of a 1024-entry sample store and gives no result. A read item
// gives one result on the output stream: the sample at a fixed-point read
// position, interpolated by nearest neighbour, linear or Catmull-Rom cubic
// as set in the mode register, with neighbour indices wrapping at the
// configured length and the output saturated to 16 bits. tuser on the
// output flags a position at or beyond the length, with sample zero.
// One item is handled at a time and tready is low while it is worked on.
// An out-of-range read skips the store and the arithmetic. Samples are
// fetched through the single store read port (one entry a cycle), and the
// one two-stage multiply-accumulate unit is used once for linear and three
// times in Horner form for cubic.
// A finished result sits in an output register; a new item is accepted
// while it waits, and a stalled receiver only holds back the next read
// result. Reset restores mode linear and length 1024; store contents are
// undefined until written.
module fractional_delay_interpolator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: entry_index [9:0], entry_value [25:10], read_position [51:26], zero
  input  logic [fdi_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // tuser: operation
  input  logic                                  s_axis_tuser,
  // Output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: sample_out [15:0]
  output logic [fdi_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // tuser: position_error
  output logic                                  m_axis_tuser,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fdi_pkg::PADDR_W-1:0]           paddr,
  input  logic [fdi_pkg::PDATA_W-1:0]           pwdata,
  output logic [fdi_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int AW = fdi_pkg::ADDR_W;
  localparam int LW = fdi_pkg::LEN_W;
  localparam int SW = fdi_pkg::SAMPLE_BITS;
  localparam int FW = fdi_pkg::FRACTION_BITS;
  localparam int CW = fdi_pkg::COEF_W;
  localparam int XW = fdi_pkg::ACC_W;

  function automatic logic signed [SW-1:0] saturate(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > fdi_pkg::SAT_HI) begin
      r = fdi_pkg::SAT_HI[SW-1:0];
    end else if (v < fdi_pkg::SAT_LO) begin
      r = fdi_pkg::SAT_LO[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [fdi_pkg::MODE_W-1:0] mode_q;
  logic [LW-1:0]              len_q;
  logic [LW-1:0]              len_act;
  logic                       cfg_wr;

  // Input fields
  logic                       in_op;
  logic [AW-1:0]              in_idx;
  logic signed [SW-1:0]       in_val;
  logic [fdi_pkg::POS_W-1:0]  in_pos;
  logic [AW-1:0]              in_ip;
  logic [FW-1:0]              in_frac;
  logic                       in_accept;

  // Address generation
  logic                       pos_err;
  logic [LW-1:0]              near_n;
  logic [AW-1:0]              near_addr;
  logic [LW-1:0]              len_m1;
  logic [AW-1:0]              prev_addr;
  logic [LW-1:0]              ip_p1;
  logic [AW-1:0]              next_addr;
  logic [LW-1:0]              next_p1;
  logic [AW-1:0]              next2_addr;
  fdi_pkg::kind_e             kind_d;

  // Sequencer
  fdi_pkg::state_e            state_q, state_d;
  fdi_pkg::kind_e             kind_q;
  logic [AW-1:0]              addr_q [4];
  logic [2:0]                 num_q;
  logic [2:0]                 rd_cnt_q, rd_cnt_d;
  logic [1:0]                 step_q, step_d;
  logic [FW-1:0]              frac_q;
  logic                       err_q;
  logic signed [SW-1:0]       x_q [4];
  logic signed [CW-1:0]       c_q [4];
  logic signed [CW-1:0]       xe [4];
  logic signed [CW-1:0]       c_d [4];

  // Store and arithmetic
  logic                       st_wr_en;
  logic                       st_rd_en;
  logic [AW-1:0]              st_rd_addr;
  logic signed [SW-1:0]       st_rd_data;
  fdi_pkg::mac_req_t          mac_req;
  logic signed [XW-1:0]       mac_res;
  logic                       mac_valid;
  logic signed [XW-1:0]       cubic_rnd;

  // Output register
  logic                       out_load;
  logic                       out_valid_q;
  logic signed [SW-1:0]       out_sample_q;
  logic                       out_err_q;
  logic signed [SW-1:0]       result;

  // Configuration port: write on the access phase, word-decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fdi_pkg::MODE_RESET;
      len_q  <= fdi_pkg::LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fdi_pkg::REG_INTERP_MODE:   mode_q <= pwdata[fdi_pkg::MODE_W-1:0];
        fdi_pkg::REG_BUFFER_LENGTH: len_q  <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fdi_pkg::REG_INTERP_MODE:   prdata = fdi_pkg::PDATA_W'(mode_q);
      fdi_pkg::REG_BUFFER_LENGTH: prdata = fdi_pkg::PDATA_W'(len_q);
      default:                    prdata = '0;
    endcase
  end

  // The length in use is clamped to between 4 and the store depth.
  always_comb begin
    priority if (len_q < fdi_pkg::LEN_MIN) begin
      len_act = fdi_pkg::LEN_MIN;
    end else if (len_q > fdi_pkg::LEN_MAX) begin
      len_act = fdi_pkg::LEN_MAX;
    end else begin
      len_act = len_q;
    end
  end

  // Unpack the input item.
  assign in_op     = s_axis_tuser;
  assign in_idx    = s_axis_tdata[fdi_pkg::IDX_LSB +: AW];
  assign in_val    = s_axis_tdata[fdi_pkg::VAL_LSB +: SW];
  assign in_pos    = s_axis_tdata[fdi_pkg::POS_LSB +: fdi_pkg::POS_W];
  assign in_ip     = in_pos[fdi_pkg::POS_W-1:FW];
  assign in_frac   = in_pos[FW-1:0];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Neighbour addresses, wrapping at the length in use.
  always_comb begin
    pos_err    = {1'b0, in_ip} >= len_act;
    near_n     = {1'b0, in_ip} + LW'(in_frac[FW-1]);
    near_addr  = (near_n >= len_act) ? '0 : near_n[AW-1:0];
    len_m1     = len_act - LW'(1);
    prev_addr  = (in_ip == '0) ? len_m1[AW-1:0] : in_ip - AW'(1);
    ip_p1      = {1'b0, in_ip} + LW'(1);
    next_addr  = (ip_p1 >= len_act) ? '0 : ip_p1[AW-1:0];
    next_p1    = {1'b0, next_addr} + LW'(1);
    next2_addr = (next_p1 >= len_act) ? '0 : next_p1[AW-1:0];
    unique case (mode_q)
      fdi_pkg::MODE_NEAREST: kind_d = fdi_pkg::KIND_NEAREST;
      fdi_pkg::MODE_CUBIC:   kind_d = fdi_pkg::KIND_CUBIC;
      default:               kind_d = fdi_pkg::KIND_LINEAR;
    endcase
  end

  // Doubled Catmull-Rom coefficients from the four fetched samples.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xe[k] = CW'(x_q[k]);
    end
    c_d[0] = -xe[0] + (xe[1] <<< 1) + xe[1] - (xe[2] <<< 1) - xe[2] + xe[3];
    c_d[1] = (xe[0] <<< 1) - (xe[1] <<< 2) - xe[1] + (xe[2] <<< 2) - xe[3];
    c_d[2] = xe[2] - xe[0];
    c_d[3] = xe[1] <<< 1;
  end

  // Sequencer: fetch samples, then drive the multiply-accumulate unit.
  always_comb begin
    state_d       = state_q;
    rd_cnt_d      = rd_cnt_q;
    step_d        = step_q;
    s_axis_tready = 1'b0;
    st_rd_en      = 1'b0;
    st_rd_addr    = addr_q[rd_cnt_q[1:0]];
    out_load      = 1'b0;
    mac_req       = '0;

    unique case (state_q)
      fdi_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        rd_cnt_d      = '0;
        step_d        = '0;
        if (s_axis_tvalid && in_op == fdi_pkg::OP_READ) begin
          state_d = pos_err ? fdi_pkg::S_DONE : fdi_pkg::S_READ;
        end
      end
      fdi_pkg::S_READ: begin
        st_rd_en = rd_cnt_q < num_q;
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == num_q) begin
          unique case (kind_q)
            fdi_pkg::KIND_NEAREST: state_d = fdi_pkg::S_DONE;
            fdi_pkg::KIND_CUBIC:   state_d = fdi_pkg::S_COEF;
            default:               state_d = fdi_pkg::S_MAC;
          endcase
        end
      end
      fdi_pkg::S_COEF: begin
        state_d = fdi_pkg::S_MAC;
      end
      fdi_pkg::S_MAC: begin
        mac_req.start = 1'b1;
        state_d       = fdi_pkg::S_MWAIT;
        if (kind_q == fdi_pkg::KIND_LINEAR) begin
          mac_req.round = 1'b1;
          mac_req.a     = XW'(x_q[1]) - XW'(x_q[0]);
          mac_req.b     = XW'(x_q[0]);
        end else begin
          unique case (step_q)
            2'd0: begin
              mac_req.guard_shift = 1'b1;
              mac_req.a           = XW'(c_q[0]);
              mac_req.b           = XW'(c_q[1]) <<< fdi_pkg::GUARD_BITS;
            end
            2'd1: begin
              mac_req.a = mac_res;
              mac_req.b = XW'(c_q[2]) <<< fdi_pkg::GUARD_BITS;
            end
            default: begin
              mac_req.a = mac_res;
              mac_req.b = XW'(c_q[3]) <<< fdi_pkg::GUARD_BITS;
            end
          endcase
        end
      end
      fdi_pkg::S_MWAIT: begin
        if (mac_valid) begin
          if (kind_q == fdi_pkg::KIND_LINEAR || step_q == 2'd2) begin
            state_d = fdi_pkg::S_DONE;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = fdi_pkg::S_MAC;
          end
        end
      end
      fdi_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = fdi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fdi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fdi_pkg::S_IDLE;
      rd_cnt_q <= '0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      step_q   <= step_d;
    end
  end

  // Item registers, fetched samples and coefficients.
  always_ff @(posedge clk_i) begin
    if (in_accept && in_op == fdi_pkg::OP_READ) begin
      kind_q <= kind_d;
      frac_q <= in_frac;
      err_q  <= pos_err;
      unique case (kind_d)
        fdi_pkg::KIND_NEAREST: begin
          num_q     <= 3'd1;
          addr_q[0] <= near_addr;
        end
        fdi_pkg::KIND_CUBIC: begin
          num_q     <= 3'd4;
          addr_q[0] <= prev_addr;
          addr_q[1] <= in_ip;
          addr_q[2] <= next_addr;
          addr_q[3] <= next2_addr;
        end
        default: begin
          num_q     <= 3'd2;
          addr_q[0] <= in_ip;
          addr_q[1] <= next_addr;
        end
      endcase
    end
    if (state_q == fdi_pkg::S_READ && rd_cnt_q != '0) begin
      x_q[rd_cnt_q[1:0] - 2'd1] <= st_rd_data;
    end
    if (state_q == fdi_pkg::S_COEF) begin
      for (int k = 0; k < 4; k++) begin
        c_q[k] <= c_d[k];
      end
    end
  end

  assign st_wr_en = in_accept && in_op == fdi_pkg::OP_WRITE;

  fdi_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (in_idx),
    .wr_data_i (in_val),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  fdi_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mac_req),
    .frac_i      (frac_q),
    .res_o       (mac_res),
    .res_valid_o (mac_valid)
  );

  // Final rounding of the cubic sum drops the guard bits and the doubling.
  assign cubic_rnd = (mac_res + XW'(2 ** fdi_pkg::GUARD_BITS)) >>> (fdi_pkg::GUARD_BITS + 1);

  always_comb begin
    if (err_q) begin
      result = '0;
    end else begin
      unique case (kind_q)
        fdi_pkg::KIND_NEAREST: result = x_q[0];
        fdi_pkg::KIND_CUBIC:   result = saturate(cubic_rnd);
        default:               result = saturate(mac_res);
      endcase
    end
  end

  // Output register decouples the result from the next item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= result;
      out_err_q    <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fdi_pkg::OUT_TDATA_W'(out_sample_q);
  assign m_axis_tuser  = out_err_q;

  // A multiply-accumulate result only comes back while the sequencer waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_valid |-> state_q == fdi_pkg::S_MWAIT)
    else $error("multiply-accumulate result outside the wait state");

  // The fetch counter never runs past the number of samples of the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fdi_pkg::S_READ |-> rd_cnt_q <= num_q)
    else $error("sample fetch counter overran");

  // A read beyond the length goes straight to the result with the error flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_op == fdi_pkg::OP_READ && pos_err
      |=> state_q == fdi_pkg::S_DONE && err_q)
    else $error("out-of-range position not flagged");

  // A new result is only ever loaded from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == fdi_pkg::S_DONE)
    else $error("result loaded outside the final state");

endmodule
